>>> rtl/lz11_pkg.sv
// ----------------------------------------------------------------------------
// LZ11 decompressor package
// Shared constants, codes and types for the LZ11 stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz11_pkg;

  localparam int unsigned WinDepth          = 4096;
  localparam int unsigned WinAddrW          = $clog2(WinDepth);
  localparam int unsigned LengthBitsDefault = 24;
  localparam int unsigned RawLenW           = 24;
  localparam int unsigned TokLenW           = 17;

  // Length bias for the 3-byte and 4-byte token forms.
  localparam logic [TokLenW-1:0] Len8Bias  = TokLenW'(17'h00011);
  localparam logic [TokLenW-1:0] Len16Bias = TokLenW'(17'h00111);

  // Top nibble of a token's first byte that selects the long forms.
  localparam logic [3:0] NibLen8  = 4'h0;
  localparam logic [3:0] NibLen16 = 4'h1;
  localparam logic [3:0] LowNibMask = 4'hF;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_DIST    = 2'd1,
    ST_EARLY_END   = 2'd2,
    ST_NOT_ALLOWED = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PH_NONE      = 5'b00001,
    PH_DIST      = 5'b00010,
    PH_LEN8      = 5'b00100,
    PH_LEN16_HI  = 5'b01000,
    PH_LEN16_LO  = 5'b10000
  } phase_e;

  // Outcome of one accepted item, handed from the decoder to the datapath.
  typedef struct packed {
    logic                emit;
    logic                from_mem;
    logic [7:0]          lit_byte;
    logic                last;
    logic                copy_pending;
    status_e             status;
    logic [WinAddrW-1:0] rd_addr;
    logic [WinAddrW-1:0] wr_addr;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/lz11_if.sv
// ----------------------------------------------------------------------------
// LZ11 decompressor channels
// Valid/ready channels for compressed input, decoded output and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz11_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, opcode, in_byte, in_last, input ready);
  modport sink   (input valid, opcode, in_byte, in_last, output ready);
endinterface

interface lz11_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       copy_pending;
  logic [1:0] status;

  modport source (output valid, out_valid, out_byte, out_last, copy_pending, status,
                  input ready);
  modport sink   (input valid, out_valid, out_byte, out_last, copy_pending, status,
                  output ready);
endinterface

interface lz11_cfg_if import lz11_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RawLenW-1:0] raw_length;

  modport source (output valid, raw_length, input ready);
  modport sink   (input valid, raw_length, output ready);
endinterface

`default_nettype wire

>>> rtl/lz11_ctrl.sv
// ----------------------------------------------------------------------------
// LZ11 token decoder
// Flag and token parsing, copy bookkeeping and error tracking for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module lz11_ctrl import lz11_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RawLenW-1:0] cfg_raw_length_i,
  input  logic               accept_i,
  input  logic               opcode_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output step_t              step_o
);

  localparam int unsigned CmpW = (LENGTH_BITS > WinAddrW) ? LENGTH_BITS : WinAddrW;

  logic [LENGTH_BITS-1:0] raw_len_q, raw_len_d;
  logic [LENGTH_BITS-1:0] produced_q, produced_d;
  logic [7:0]             flags_q, flags_d;
  logic [3:0]             flags_left_q, flags_left_d;
  phase_e                 phase_q, phase_d;
  logic [TokLenW-1:0]     tok_len_q, tok_len_d;
  logic [WinAddrW-1:0]    tok_dist_q, tok_dist_d;
  logic [TokLenW-1:0]     copy_rem_q, copy_rem_d;
  status_e                err_q, err_d;
  logic                   ended_q, ended_d;

  logic [LENGTH_BITS+RawLenW-1:0] cfg_ext;
  logic [LENGTH_BITS-1:0]         produced_inc;
  logic [CmpW-1:0]                prod_ext;
  logic [CmpW-1:0]                src_full;
  logic [3:0]                     nib;
  logic [WinAddrW-1:0]            dist_new;
  logic                           dist_bad;
  step_t                          step_d;

  assign cfg_ext      = {{LENGTH_BITS{1'b0}}, cfg_raw_length_i};
  assign raw_len_d    = cfg_ext[LENGTH_BITS-1:0];
  assign produced_inc = produced_q + 1'b1;
  assign prod_ext     = CmpW'(produced_q);
  assign src_full     = prod_ext - CmpW'(tok_dist_q) - CmpW'(1);
  assign nib          = in_byte_i[7:4];
  assign dist_new     = {tok_dist_q[3:0], in_byte_i};
  assign dist_bad     = CmpW'(dist_new) >= prod_ext;

  always_comb begin
    produced_d   = produced_q;
    flags_d      = flags_q;
    flags_left_d = flags_left_q;
    phase_d      = phase_q;
    tok_len_d    = tok_len_q;
    tok_dist_d   = tok_dist_q;
    copy_rem_d   = copy_rem_q;
    err_d        = err_q;
    ended_d      = ended_q;

    step_d              = '0;
    step_d.status       = ST_OK;
    step_d.lit_byte     = in_byte_i;
    step_d.rd_addr      = src_full[WinAddrW-1:0];
    step_d.wr_addr      = prod_ext[WinAddrW-1:0];

    if (err_q != ST_OK) begin
      step_d.status = err_q;
    end else if (opcode_i == OP_DRAIN) begin
      if (copy_rem_q == '0) begin
        step_d.status = ST_NOT_ALLOWED;
      end else begin
        step_d.emit     = 1'b1;
        step_d.from_mem = 1'b1;
        produced_d      = produced_inc;
        copy_rem_d      = copy_rem_q - 1'b1;
        if (produced_inc >= raw_len_q) begin
          copy_rem_d = '0;
        end
        if (copy_rem_d == '0 && ended_q && produced_inc < raw_len_q) begin
          err_d         = ST_EARLY_END;
          step_d.status = ST_EARLY_END;
        end
      end
    end else if (copy_rem_q != '0 || ended_q) begin
      step_d.status = ST_NOT_ALLOWED;
    end else begin
      if (in_last_i) begin
        ended_d = 1'b1;
      end
      // Once raw length is reached, further compressed bytes are dropped.
      if (produced_q < raw_len_q) begin
        unique case (phase_q)
          PH_NONE: begin
            if (flags_left_q == '0) begin
              flags_d      = in_byte_i;
              flags_left_d = 4'd8;
            end else begin
              flags_d      = {flags_q[6:0], 1'b0};
              flags_left_d = flags_left_q - 1'b1;
              if (!flags_q[7]) begin
                step_d.emit = 1'b1;
                produced_d  = produced_inc;
              end else if (nib == NibLen8) begin
                tok_len_d = {9'd0, in_byte_i[3:0] & LowNibMask, 4'd0};
                phase_d   = PH_LEN8;
              end else if (nib == NibLen16) begin
                tok_len_d = {1'b0, in_byte_i[3:0] & LowNibMask, 12'd0};
                phase_d   = PH_LEN16_HI;
              end else begin
                tok_len_d  = TokLenW'(nib) + TokLenW'(1);
                tok_dist_d = WinAddrW'(in_byte_i[3:0] & LowNibMask);
                phase_d    = PH_DIST;
              end
            end
          end
          PH_DIST: begin
            tok_dist_d = dist_new;
            phase_d    = PH_NONE;
            if (dist_bad) begin
              err_d         = ST_BAD_DIST;
              step_d.status = ST_BAD_DIST;
            end else begin
              copy_rem_d = tok_len_q;
            end
          end
          PH_LEN8: begin
            tok_len_d  = (tok_len_q | TokLenW'(nib)) + Len8Bias;
            tok_dist_d = WinAddrW'(in_byte_i[3:0] & LowNibMask);
            phase_d    = PH_DIST;
          end
          PH_LEN16_HI: begin
            tok_len_d = tok_len_q | {5'd0, in_byte_i, 4'd0};
            phase_d   = PH_LEN16_LO;
          end
          PH_LEN16_LO: begin
            tok_len_d  = (tok_len_q | TokLenW'(nib)) + Len16Bias;
            tok_dist_d = WinAddrW'(in_byte_i[3:0] & LowNibMask);
            phase_d    = PH_DIST;
          end
          default: begin
            phase_d = PH_NONE;
          end
        endcase
      end
      if (in_last_i && err_d == ST_OK) begin
        if (phase_d != PH_NONE || (copy_rem_d == '0 && produced_d < raw_len_q)) begin
          err_d         = ST_EARLY_END;
          step_d.status = ST_EARLY_END;
          copy_rem_d    = '0;
        end
      end
    end

    if (err_d != ST_OK) begin
      copy_rem_d = '0;
    end
    step_d.copy_pending = (copy_rem_d != '0);
    step_d.last         = step_d.emit && (produced_d == raw_len_q);
  end

  assign step_o = step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q <= '0;
    end else if (cfg_we_i) begin
      raw_len_q <= raw_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q   <= '0;
      flags_q      <= '0;
      flags_left_q <= '0;
      phase_q      <= PH_NONE;
      tok_len_q    <= '0;
      tok_dist_q   <= '0;
      copy_rem_q   <= '0;
      err_q        <= ST_OK;
      ended_q      <= 1'b0;
    end else if (accept_i) begin
      produced_q   <= produced_d;
      flags_q      <= flags_d;
      flags_left_q <= flags_left_d;
      phase_q      <= phase_d;
      tok_len_q    <= tok_len_d;
      tok_dist_q   <= tok_dist_d;
      copy_rem_q   <= copy_rem_d;
      err_q        <= err_d;
      ended_q      <= ended_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lz11_stream_decompressor_top.sv
// ----------------------------------------------------------------------------
// LZ11 stream decompressor
// Decodes the LZ11 payload one item per cycle into bytes while not stalled.
// ----------------------------------------------------------------------------
// The cfg channel writes raw_length, the number of decoded bytes expected; it
// is always ready. The user must write it only while no item is in flight; the
// block does not enforce this. The in channel takes one item per cycle unless
// stalled: opcode 0 carries a compressed byte, opcode 1 asks for the next byte
// of a pending match copy. The feeder sends drain items as long as
// copy_pending was high on the previous result. Every accepted item gives
// exactly one out item, via the synchronous read of the 4096-byte history
// memory in the read stage, then the output register. A copy that reads the
// byte written just before it is served by forwarding, so throughput is one
// item per cycle for literals and copies at any distance. When the receiver
// stalls, one item waits in the output register and one in the read stage,
// and in.ready then falls. Reset clears the decoder state and raw_length; the
// history memory is not cleared and is never read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module lz11_stream_decompressor_top import lz11_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lz11_cfg_if.sink   cfg_i,
  lz11_in_if.sink    in_i,
  lz11_out_if.source out_o
);

  logic                cfg_we;
  logic                in_accept;
  step_t               step;

  logic                s1_valid_q, s1_valid_d;
  step_t               s1_step_q;
  logic                s1_fwd_q;
  logic [7:0]          s1_fwd_byte_q;
  logic                s1_adv;
  logic [7:0]          s1_byte;

  logic                s2_valid_q, s2_valid_d;
  logic                s2_out_valid_q;
  logic [7:0]          s2_byte_q;
  logic                s2_last_q;
  logic                s2_pending_q;
  status_e             s2_status_q;

  logic [7:0]          hist_mem [WinDepth];
  logic [7:0]          mem_rdata_q;
  logic                mem_we;
  logic                mem_re;
  logic                fwd_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;

  assign s1_adv      = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_accept   = in_i.valid && in_i.ready;

  lz11_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_raw_length_i (cfg_i.raw_length),
    .accept_i         (in_accept),
    .opcode_i         (in_i.opcode),
    .in_byte_i        (in_i.in_byte),
    .in_last_i        (in_i.in_last),
    .step_o           (step)
  );

  always_comb begin
    if (!s1_step_q.emit) begin
      s1_byte = 8'h00;
    end else if (!s1_step_q.from_mem) begin
      s1_byte = s1_step_q.lit_byte;
    end else if (s1_fwd_q) begin
      s1_byte = s1_fwd_byte_q;
    end else begin
      s1_byte = mem_rdata_q;
    end
  end

  // The byte leaving the read stage is written back as the next item reads;
  // the memory returns old data then, so that byte is forwarded instead.
  assign mem_we  = s1_adv && s1_step_q.emit;
  assign mem_re  = in_accept && step.from_mem;
  assign fwd_hit = mem_we && mem_re && (s1_step_q.wr_addr == step.rd_addr);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[s1_step_q.wr_addr] <= s1_byte;
    end
    if (mem_re) begin
      mem_rdata_q <= hist_mem[step.rd_addr];
    end
  end

  assign s1_valid_d = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_step_q     <= step;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_byte_q <= s1_byte;
    end
  end

  assign s2_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : s2_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_out_valid_q <= s1_step_q.emit;
      s2_byte_q      <= s1_byte;
      s2_last_q      <= s1_step_q.last;
      s2_pending_q   <= s1_step_q.copy_pending;
      s2_status_q    <= s1_step_q.status;
    end
  end

  assign out_o.valid        = s2_valid_q;
  assign out_o.out_valid    = s2_out_valid_q;
  assign out_o.out_byte     = s2_byte_q;
  assign out_o.out_last     = s2_last_q;
  assign out_o.copy_pending = s2_pending_q;
  assign out_o.status       = s2_status_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_step_q))
    else $error("read stage lost or changed a stalled item");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item did not reach the read stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_o.ready |=> s2_valid_q)
    else $error("output register dropped an item that was not taken");

  a_fwd_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_fwd_q |-> s1_step_q.from_mem && s1_step_q.emit)
    else $error("forwarded byte flagged on an item without a history read");

endmodule

`default_nettype wire
